[design/pcd_pkg.sv]
// pcd_pkg: shared types and fixed field widths for the palette color dedup block.
// No dependencies.

package pcd_pkg;

	localparam int CHAN_W  = 16;          // one color component
	localparam int COLOR_W = 3 * CHAN_W;  // packed red, green, blue
	localparam int INDEX_W = 8;           // color_index field
	localparam int USED_W  = 9;           // used_count field

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_FINISH
	} pcd_state_t;

endpackage : pcd_pkg

[design/palette_color_dedup.sv]
// palette_color_dedup: unique-color table with a sequential search of a 48-bit store.
// Depends on pcd_pkg.
//
//  channel   | handshake         | payload
//  ----------+-------------------+------------------------------------------------
//  entry in  | start & !busy     | first_entry, entry_red, entry_green, entry_blue
//  result out| done (one cycle)  | color_index, is_new, overflow, used_count
//
// Search: from transfer to done, the block reads one stored color per cycle
//   through a registered read port and compares it with the key, then ends in
//   a finish state that writes the store and registers the result. A match at
//   index k ends the search early; a first entry or an empty table skips it.
// The single read port of the color store sets that rate: one entry a cycle.
// Reset clears the control state and the unique count; the store is not cleared,
//   since only entries below the count are ever compared.
// busy drops in the cycle that done is shown, so the next entry may transfer then.
// The receiver cannot stall: each result is valid for exactly the done cycle.

module palette_color_dedup #(
	parameter int unsigned MAX_COLORS = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         first_entry,
	input  logic [pcd_pkg::CHAN_W-1:0]   entry_red,
	input  logic [pcd_pkg::CHAN_W-1:0]   entry_green,
	input  logic [pcd_pkg::CHAN_W-1:0]   entry_blue,
	output logic                         done,
	output logic [pcd_pkg::INDEX_W-1:0]  color_index,
	output logic                         is_new,
	output logic                         overflow,
	output logic [pcd_pkg::USED_W-1:0]   used_count
);

	import pcd_pkg::*;

	// address bits of the store, and count bits (count may equal MAX_COLORS)
	localparam int AW = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1;
	localparam int CW = $clog2(MAX_COLORS + 1);

	pcd_state_t state_q, next_state;

	logic [COLOR_W-1:0] store_mem [MAX_COLORS];
	logic [COLOR_W-1:0] rdata_s1;   // registered read data
	logic               cmp_v_s1;   // rdata_s1 holds an entry to compare
	logic [CW-1:0]      cmp_idx_s1; // index of that entry

	logic [COLOR_W-1:0] key_q;      // color being looked up
	logic [CW-1:0]      count_q;    // unique colors in the current palette
	logic [CW-1:0]      scan_q;     // next store index to read
	logic               found_q;
	logic [CW-1:0]      hit_idx_q;

	logic               done_q;
	logic [INDEX_W-1:0] color_index_q;
	logic               is_new_q;
	logic               overflow_q;
	logic [USED_W-1:0]  used_count_q;

	logic accept;
	logic rd_en;
	logic wr_en;
	logic hit;
	logic last_miss;
	logic full;
	logic [CW-1:0] count_next;

	assign accept    = start & ~busy;
	assign hit       = cmp_v_s1 && (rdata_s1 == key_q);
	// last stored entry compared without a match
	assign last_miss = cmp_v_s1 && !hit && (CW'(cmp_idx_s1 + CW'(1)) == count_q);
	assign full      = (count_q == CW'(MAX_COLORS));
	assign count_next = wr_en ? CW'(count_q + CW'(1)) : count_q;

	// ---------------- next state ----------------
	always_comb begin
		next_state = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					// empty table: nothing to search, go straight to append
					next_state = (first_entry || count_q == '0) ? ST_FINISH : ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (hit || last_miss) begin
					next_state = ST_FINISH;
				end
			end
			ST_FINISH: begin
				next_state = ST_IDLE;
			end
			default: begin
				next_state = ST_IDLE;
			end
		endcase
	end

	// ---------------- state outputs ----------------
	always_comb begin
		busy  = 1'b1;
		rd_en = 1'b0;
		wr_en = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
			end
			ST_SEARCH: begin
				// stop issuing reads past the count or once a match is in hand
				rd_en = (scan_q < count_q) && !hit;
			end
			ST_FINISH: begin
				wr_en = !found_q && !full;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	// ---------------- control registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			scan_q   <= '0;
			cmp_v_s1 <= 1'b0;
			found_q  <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			state_q  <= next_state;
			cmp_v_s1 <= rd_en;
			done_q   <= (state_q == ST_FINISH);
			if (accept) begin
				scan_q  <= '0;
				found_q <= 1'b0;
				if (first_entry) begin
					count_q <= '0;
				end
			end else begin
				if (rd_en) begin
					scan_q <= CW'(scan_q + CW'(1));
				end
				if (state_q == ST_SEARCH && hit) begin
					found_q <= 1'b1;
				end
				if (state_q == ST_FINISH) begin
					count_q <= count_next;
				end
			end
		end
	end

	// ---------------- payload registers ----------------
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= {entry_red, entry_green, entry_blue};
		end
		if (rd_en) begin
			cmp_idx_s1 <= scan_q;
		end
		if (state_q == ST_SEARCH && hit) begin
			hit_idx_q <= cmp_idx_s1;
		end
		if (state_q == ST_FINISH) begin
			is_new_q     <= wr_en;
			overflow_q   <= !found_q && full;
			used_count_q <= USED_W'(32'(count_next));
			if (found_q) begin
				color_index_q <= INDEX_W'(32'(hit_idx_q));
			end else if (full) begin
				color_index_q <= '0;
			end else begin
				color_index_q <= INDEX_W'(32'(count_q));
			end
		end
	end

	// ---------------- color store ----------------
	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_mem[count_q[AW-1:0]] <= key_q;
		end
		if (rd_en) begin
			rdata_s1 <= store_mem[scan_q[AW-1:0]];
		end
	end

	assign done        = done_q;
	assign color_index = color_index_q;
	assign is_new      = is_new_q;
	assign overflow    = overflow_q;
	assign used_count  = used_count_q;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_COLORS))
		else $error("unique count above store depth");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("busy not raised after transfer");

	a_new_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(done && is_new) |-> (count_q == CW'($past(count_q) + CW'(1))))
		else $error("new color did not advance the count");
`endif

endmodule : palette_color_dedup

[tb/sv/palette_color_dedup_chk.sv]
// palette_color_dedup_chk: tracks the unique-color table on the side and checks every result.
// Depends on pcd_pkg; sits beside palette_color_dedup and only watches its ports.

module palette_color_dedup_chk #(
	parameter int unsigned MAX_COLORS = 256
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        busy,
	input  logic                        first_entry,
	input  logic [pcd_pkg::CHAN_W-1:0]  entry_red,
	input  logic [pcd_pkg::CHAN_W-1:0]  entry_green,
	input  logic [pcd_pkg::CHAN_W-1:0]  entry_blue,
	input  logic                        done,
	input  logic [pcd_pkg::INDEX_W-1:0] color_index,
	input  logic                        is_new,
	input  logic                        overflow,
	input  logic [pcd_pkg::USED_W-1:0]  used_count,
	output int                          fail_count,
	output int                          pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import pcd_pkg::*;

	typedef struct packed {
		logic [INDEX_W-1:0] index;
		logic               is_new;
		logic               overflow;
		logic [USED_W-1:0]  used;
	} dedup_result_t;

	// shadow of the color table
	logic [COLOR_W-1:0] palette_colors [MAX_COLORS];
	bit [31:0]          stored_count = '0;
	dedup_result_t      predicted_lookups [$];

	initial begin
		fail_count = 0;
		pending    = 0;
	end

	// first-match search from index 0; append on miss, overflow when full
	function automatic dedup_result_t lookup_or_append(input logic fe,
			input logic [COLOR_W-1:0] color);
		dedup_result_t res;
		bit [31:0]     hit_idx;
		bit            found;
		res     = '0;
		hit_idx = '0;
		found   = 1'b0;
		if (fe)
			stored_count = '0;
		for (int j = 0; j < stored_count; j++) begin
			if (palette_colors[j] == color) begin
				hit_idx = j;
				found   = 1'b1;
				break;
			end
		end
		if (!found) begin
			if (stored_count < MAX_COLORS) begin
				hit_idx                      = stored_count;
				palette_colors[stored_count] = color;
				stored_count                 = stored_count + 1;
				res.is_new                   = 1'b1;
			end else begin
				hit_idx      = '0;
				res.overflow = 1'b1;
			end
		end
		res.index = hit_idx[INDEX_W-1:0];
		res.used  = stored_count[USED_W-1:0];
		return res;
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0d actual %0d",
				$realtime, name, want, got);
			fail_count++;
		end
	endtask

	// results are retired before the transfer at the same edge is predicted
	always @(posedge clk) begin
		dedup_result_t want;
		if (arst_n) begin
			if (done) begin
				if (predicted_lookups.size() == 0) begin
					$display("%0t ns: unexpected result, expected none actual index %0d used %0d",
						$realtime, color_index, used_count);
					fail_count++;
				end else begin
					want = predicted_lookups.pop_front();
					check_field("color_index", want.index, color_index);
					check_field("is_new", want.is_new, is_new);
					check_field("overflow", want.overflow, overflow);
					check_field("used_count", want.used, used_count);
				end
			end
			if (start && !busy)
				predicted_lookups.push_back(lookup_or_append(first_entry,
					{entry_red, entry_green, entry_blue}));
			pending = predicted_lookups.size();
		end
	end

endmodule : palette_color_dedup_chk

[tb/sv/palette_color_dedup_tb.sv]
// palette_color_dedup_tb: stimulus and verdict for the palette color dedup block.
// Depends on pcd_pkg, palette_color_dedup and palette_color_dedup_chk.

module palette_color_dedup_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import pcd_pkg::*;

	localparam int unsigned MAX_COLORS = 256;
	localparam int RANDOM_ENTRIES = 780;
	localparam int QUIET_TAIL     = 120;    // final entries sent back to back
	localparam int CYCLE_LIMIT    = 1_000_000;

	// short palettes reuse a small color set; fill palettes run the table past full
	typedef enum {PAL_SHORT, PAL_FILL} palette_kind_t;

	logic                 clk;
	logic                 arst_n      = 1'b0;
	logic                 start       = 1'b0;
	logic                 busy;
	logic                 first_entry = 1'b0;
	logic [CHAN_W-1:0]    entry_red   = '0;
	logic [CHAN_W-1:0]    entry_green = '0;
	logic [CHAN_W-1:0]    entry_blue  = '0;
	logic                 done;
	logic [INDEX_W-1:0]   color_index;
	logic                 is_new;
	logic                 overflow;
	logic [USED_W-1:0]    used_count;
	int                   fail_count;
	int                   pending;
	int                   cycles = 0;
	bit                   gaps_on = 1'b1;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	palette_color_dedup #(
		.MAX_COLORS(MAX_COLORS)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.first_entry (first_entry),
		.entry_red   (entry_red),
		.entry_green (entry_green),
		.entry_blue  (entry_blue),
		.done        (done),
		.color_index (color_index),
		.is_new      (is_new),
		.overflow    (overflow),
		.used_count  (used_count)
	);

	palette_color_dedup_chk #(
		.MAX_COLORS(MAX_COLORS)
	) chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.first_entry (first_entry),
		.entry_red   (entry_red),
		.entry_green (entry_green),
		.entry_blue  (entry_blue),
		.done        (done),
		.color_index (color_index),
		.is_new      (is_new),
		.overflow    (overflow),
		.used_count  (used_count),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	// watchdog: a hung search or a lost done ends up here
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// component values lean on the extremes so both ends show up often
	function automatic logic [CHAN_W-1:0] rand_chan();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			default: return CHAN_W'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic logic [COLOR_W-1:0] rand_color();
		return {rand_chan(), rand_chan(), rand_chan()};
	endfunction

	// One entry transfer. An optional idle burst goes first, with start low.
	// Fields change only at an edge; start stays high until an edge sees busy low,
	// which is the edge the block takes the entry.
	task automatic send_entry(input logic fe, input logic [COLOR_W-1:0] color);
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		start       <= 1'b1;
		first_entry <= fe;
		entry_red   <= color[3*CHAN_W-1:2*CHAN_W];
		entry_green <= color[2*CHAN_W-1:CHAN_W];
		entry_blue  <= color[CHAN_W-1:0];
		do
			@(posedge clk);
		while (busy);
	endtask

	initial begin
		logic [COLOR_W-1:0] recent [$];   // colors this palette may repeat
		logic [COLOR_W-1:0] color;
		palette_kind_t      kind;
		int                 sent;
		int                 palette_no;
		int                 len;
		int                 pool_size;
		bit                 fe;
		bit                 fresh;

		sent       = 0;
		palette_no = 0;

		// reset held low from the start, released at an edge
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed ---
		// all-zero and all-ones colors, then single-component extremes
		send_entry(1'b1, {16'h0000, 16'h0000, 16'h0000});
		send_entry(1'b0, {16'hFFFF, 16'hFFFF, 16'hFFFF});
		send_entry(1'b0, {16'h0000, 16'h0000, 16'h0000});   // hit at index 0
		send_entry(1'b0, {16'hFFFF, 16'h0000, 16'h0000});
		send_entry(1'b0, {16'h0000, 16'hFFFF, 16'h0000});
		send_entry(1'b0, {16'h0000, 16'h0000, 16'hFFFF});
		send_entry(1'b0, {16'hFFFF, 16'hFFFF, 16'hFFFF});   // hit at index 1
		send_entry(1'b0, {16'h0000, 16'h0000, 16'hFFFF});   // hit at last index
		// new palette: stale table contents must not match
		send_entry(1'b1, {16'h0000, 16'h0000, 16'hFFFF});
		send_entry(1'b0, {16'hFFFF, 16'h0000, 16'h0000});
		send_entry(1'b0, {16'hFFFF, 16'hFFFF, 16'hFFFF});
		// back-to-back restarts
		send_entry(1'b1, {16'h0000, 16'h0000, 16'h0000});
		send_entry(1'b1, {16'h0000, 16'h0000, 16'h0000});
		// new colors, one differing from all-ones in one bit of one component, then a hit at index 1
		send_entry(1'b0, {16'h1234, 16'h5678, 16'h9ABC});
		send_entry(1'b0, {16'hFFFF, 16'hFFFF, 16'hFFFE});
		send_entry(1'b0, {16'h7FFF, 16'h8000, 16'h0001});
		send_entry(1'b0, {16'h1234, 16'h5678, 16'h9ABC});

		// --- random palettes ---
		// Two fill palettes push past MAX_COLORS unique colors, so the table hits
		// full, then sees overflows mixed with hits deep in the table.
		// Short palettes repeat a small pool and now and then restart mid-way.
		while (sent < RANDOM_ENTRIES) begin
			kind = (palette_no == 1 || palette_no == 4) ? PAL_FILL : PAL_SHORT;
			recent.delete();
			if (kind == PAL_SHORT) begin
				pool_size = $urandom_range(1, 24);
				for (int i = 0; i < pool_size; i++)
					recent.push_back(rand_color());
				len = $urandom_range(1, 40);
			end else begin
				len = MAX_COLORS + 60 + $urandom_range(0, 20);
			end
			for (int i = 0; i < len; i++) begin
				gaps_on = (sent < RANDOM_ENTRIES - QUIET_TAIL);
				fe = (i == 0) || (kind == PAL_SHORT && $urandom_range(0, 39) == 0);
				if (kind == PAL_FILL)
					fresh = (i == 0) || $urandom_range(0, 7) != 0;
				else
					fresh = $urandom_range(0, 15) == 0;
				if (fresh) begin
					color = (kind == PAL_FILL) ? COLOR_W'({$urandom(), $urandom()})
						: rand_color();
					if (kind == PAL_FILL)
						recent.push_back(color);
				end else begin
					color = recent[$urandom_range(0, recent.size() - 1)];
				end
				send_entry(fe, color);
				sent++;
			end
			palette_no++;
		end

		// --- drain ---
		// let the last search finish, then watch a full search time for strays
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (MAX_COLORS + 4) @(posedge clk);
		@(negedge clk);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule : palette_color_dedup_tb
